// ===== rtl/core/shps_pkg.sv =====
// Shared types, constants and helper functions for the sliding Hamming
// pattern search unit. No dependencies; every other file imports this package.
package shps_pkg;

  localparam int WINDOW_BITS     = 25;
  localparam int MAX_STREAM_BITS = 4096;

  localparam int PATTERN_W = 25;
  localparam int POS_W     = 12;
  localparam int DIST_W    = 5;
  localparam int COUNT_W   = $clog2(MAX_STREAM_BITS + 1);
  localparam int POPC_W    = $clog2(WINDOW_BITS + 1);

  // Population count is built as small groups summed in a second level.
  localparam int GROUP_BITS = 5;
  localparam int NUM_GROUPS = (WINDOW_BITS + GROUP_BITS - 1) / GROUP_BITS;
  localparam int GROUP_W    = $clog2(GROUP_BITS + 1);

  typedef logic [WINDOW_BITS-1:0] window_t;

  typedef struct packed {
    logic stream_bit;
    logic last_bit;
  } shps_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  best_position;
    logic [DIST_W-1:0] best_distance;
    logic              found;
    logic              overflow;
  } shps_result_t;

  function automatic logic [POPC_W-1:0] popcount(input window_t v);
    logic [NUM_GROUPS*GROUP_BITS-1:0] padded;
    logic [GROUP_W-1:0]               group_sum [NUM_GROUPS];
    logic [POPC_W-1:0]                total;
    padded = '0;
    padded[WINDOW_BITS-1:0] = v;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_sum[g] = '0;
      for (int b = 0; b < GROUP_BITS; b++) begin
        group_sum[g] = group_sum[g] + GROUP_W'(padded[g*GROUP_BITS + b]);
      end
    end
    total = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      total = total + POPC_W'(group_sum[g]);
    end
    return total;
  endfunction

endpackage

// ===== rtl/core/shps_if.sv =====
// Valid/ready channel interfaces for the input bit stream and the result.
// Depends on shps_pkg for field widths.
interface shps_stream_if;
  logic valid;
  logic ready;
  logic stream_bit;
  logic last_bit;

  modport source (output valid, output stream_bit, output last_bit, input ready);
  modport sink   (input valid, input stream_bit, input last_bit, output ready);
endinterface

interface shps_result_if
  import shps_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  best_position;
  logic [DIST_W-1:0] best_distance;
  logic              found;
  logic              overflow;

  modport source (output valid, output best_position, output best_distance,
                  output found, output overflow, input ready);
  modport sink   (input valid, input best_position, input best_distance,
                  input found, input overflow, output ready);
endinterface

// ===== rtl/core/sliding_hamming_pattern_search_unit.sv =====
// Top level of the sliding Hamming pattern search unit: input register,
// search core, result register and the pattern register. Depends on
// shps_pkg, shps_if and shps_search_core.
//
// Usage: the stream channel carries one received bit per transaction, with
// last_bit marking the final bit of a stream. The result channel carries at
// most one transaction per stream: either at once when a window matches the
// pattern exactly (remaining bits up to last_bit are then dropped), or at the
// last bit with the best distance and its first window start position. When
// no full window was seen, found is low and position and distance are zero.
// The user loads the pattern via cfg_write_en/cfg_write_data while the unit
// is idle (not enforced here); it applies from the next compared window.
// Timing: a bit that causes a result is first captured in the input register;
// while it is held there, the popcount, compare and state update form the
// result, which loads into the result register when the bit steps on.
// Throughput is one bit per cycle unless a result is stalled, set by the
// combinational popcount and best-distance compare feeding the search
// state.
// Reset is synchronous: it clears the pattern, the search state and both
// valid flags. When the receiver stalls the result register holds its
// transaction; bits that produce no result keep flowing, and a bit that would
// produce a second result waits in the input register, which then deasserts
// ready on the stream channel.
module sliding_hamming_pattern_search_unit
  import shps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  shps_stream_if.sink          stream,
  shps_result_if.source        result,
  input  logic                 cfg_write_en,
  input  logic [PATTERN_W-1:0] cfg_write_data
);

  logic [PATTERN_W-1:0] pattern;

  logic         item_valid;
  shps_item_t   item;
  logic         step;
  logic         emit;
  shps_result_t core_result;

  logic         res_valid;
  shps_result_t res_data;

  // The pattern register has no handshake; writes land on the next edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= '0;
    end else if (cfg_write_en) begin
      pattern <= cfg_write_data;
    end
  end

  // The held bit moves on unless it produces a result while the result
  // register is still occupied and not being taken.
  assign step         = item_valid && (!emit || !res_valid || result.ready);
  assign stream.ready = !item_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (stream.ready) begin
      item_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      item.stream_bit <= stream.stream_bit;
      item.last_bit   <= stream.last_bit;
    end
  end

  shps_search_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .item    (item),
    .pattern (pattern),
    .emit    (emit),
    .result  (core_result)
  );

  // Result register; it stays loaded until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step && emit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      res_data <= core_result;
    end
  end

  assign result.valid         = res_valid;
  assign result.best_position = res_data.best_position;
  assign result.best_distance = res_data.best_distance;
  assign result.found         = res_data.found;
  assign result.overflow      = res_data.overflow;

endmodule

// ===== rtl/core/shps_search_core.sv =====
// Search state and per-bit datapath: window shift, popcount, best tracking.
// Depends on shps_pkg.
module shps_search_core
  import shps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  shps_item_t           item,
  input  logic [PATTERN_W-1:0] pattern,
  output logic                 emit,
  output shps_result_t         result
);

  window_t            window;
  logic [COUNT_W-1:0] bits_seen;
  logic               have_window;
  logic [POPC_W-1:0]  lowest_distance;
  logic [POS_W-1:0]   lowest_position;
  logic               exact_match_done;
  logic               length_exceeded;

  window_t            window_next;
  logic [POPC_W-1:0]  distance;
  logic [COUNT_W-1:0] pos_full;
  logic               active;
  logic               can_shift;
  logic               full;
  logic               compared;
  logic               better;
  logic               exact;
  logic               have_next;
  logic [POPC_W-1:0]  lowest_distance_next;
  logic [POS_W-1:0]   lowest_position_next;
  logic               length_exceeded_next;

  always_comb begin
    window_next = {item.stream_bit, window[WINDOW_BITS-1:1]};
    distance    = popcount(window_next ^ window_t'(pattern));
    pos_full    = bits_seen - COUNT_W'(WINDOW_BITS - 1);
    active      = !exact_match_done;
    can_shift   = bits_seen < COUNT_W'(MAX_STREAM_BITS);
    full        = bits_seen >= COUNT_W'(WINDOW_BITS - 1);
    compared    = active && can_shift && full;
    better      = !have_window || (distance < lowest_distance);
    exact       = compared && (distance == '0);
    emit        = exact || (active && item.last_bit);

    have_next            = have_window || compared;
    lowest_distance_next = (compared && better) ? distance : lowest_distance;
    lowest_position_next = (compared && better) ? pos_full[POS_W-1:0] : lowest_position;
    length_exceeded_next = length_exceeded || (active && !can_shift);

    result.found         = have_next;
    result.best_position = have_next ? lowest_position_next : '0;
    result.best_distance = have_next ? DIST_W'(lowest_distance_next) : '0;
    result.overflow      = length_exceeded_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_bit)) begin
      window           <= '0;
      bits_seen        <= '0;
      have_window      <= 1'b0;
      lowest_distance  <= '1;
      lowest_position  <= '0;
      exact_match_done <= 1'b0;
      length_exceeded  <= 1'b0;
    end else if (step && active) begin
      if (can_shift) begin
        window    <= window_next;
        bits_seen <= bits_seen + COUNT_W'(1);
      end
      have_window      <= have_next;
      lowest_distance  <= lowest_distance_next;
      lowest_position  <= lowest_position_next;
      exact_match_done <= exact;
      length_exceeded  <= length_exceeded_next;
    end
  end

endmodule

// ===== rtl/core/shps_checker.sv =====
// Port-level assertions for the sliding Hamming pattern search unit, bound
// to the top level. Depends on shps_pkg and sliding_hamming_pattern_search_unit.
module shps_checker
  import shps_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic [POS_W-1:0]  best_position,
  input logic [DIST_W-1:0] best_distance,
  input logic              found,
  input logic              overflow
);

  // A stalled result transaction keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(best_position) &&
      $stable(best_distance) && $stable(found) && $stable(overflow))
    else $error("result changed while stalled");

  // Without a compared window the position and distance are zero.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !found |-> best_position == '0 && best_distance == '0)
    else $error("nonzero position or distance without a window");

  // A distance can never exceed the window length.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> best_distance <= DIST_W'(WINDOW_BITS))
    else $error("distance larger than the window");

  // Reset empties the result register.
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind sliding_hamming_pattern_search_unit shps_checker u_shps_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .best_position (result.best_position),
  .best_distance (result.best_distance),
  .found         (result.found),
  .overflow      (result.overflow)
);
